FILE: hdl/dmxlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmxlb_pkg
// Shared types and constants for the DMX level store with blink and timeout.
// ----------------------------------------------------------------------------
package dmxlb_pkg;

  // Number of stored DMX channels.
  localparam int CHANNELS = 4;
  // Width of the led_mask field and the channels that appear in it.
  localparam int MASK_BITS = 4;
  localparam int MASK_CH = (CHANNELS < MASK_BITS) ? CHANNELS : MASK_BITS;
  // Address width of the level memory.
  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Timeout ticks per second and counter geometry.
  localparam int TICKS_PER_SECOND = 10000;
  localparam int TO_W = 22;
  localparam int TO_MAX = 255 * TICKS_PER_SECOND;

  // Blink counter and divider geometry.
  localparam int BLINK_W = 32;
  localparam int STEP_W = $clog2(BLINK_W);
  localparam int PERIOD_OFFSET = 10;

  typedef enum logic [1:0] {
    REQ_WRITE_LEVEL  = 2'd0,
    REQ_ACTIVITY     = 2'd1,
    REQ_BLINK_TICK   = 2'd2,
    REQ_TIMEOUT_TICK = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/dmx_level_blink_with_timeout.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_level_blink_with_timeout
// DMX level store that blinks one LED per channel and clears on a timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_* stream. req_type (in s_tuser) selects a level
//   write, a DMX activity restart, a blink tick or a 10 kHz timeout tick.
//   Only a blink tick produces a result: the LED mask on the m_* stream.
//   The user writes the timeout in seconds on the cfg_* channel while idle;
//   the block itself does not enforce this.
// Processing:
//   Level writes, restarts and timeout ticks complete in the cycle of their
//   transfer, so such items can follow back to back. A blink tick walks the
//   shown channels one by one: a lit channel takes a memory read state, a
//   load state and a one-bit-per-cycle restoring divider that finds
//   blink_count / period; a dark channel takes only the read and load
//   states. The block takes no new items until the finished mask has been
//   loaded into the output register.
// Reset:
//   rst clears the valid bit of every stored level (all levels read as
//   zero), the blink count, the timeout counter and the timeout setting.
// Stalls:
//   The mask sits in an output register. The block keeps taking items while
//   it waits; a later blink tick holds in its final state until the
//   previous mask has been transferred.
// ----------------------------------------------------------------------------
module dmx_level_blink_with_timeout (
  input  wire         clk,
  input  wire         rst,
  // Configuration write channel: timeout_seconds.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data,
  // Input stream.
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [1:0] channel, [9:2] level, [15:10] zero
  input  wire  [1:0]  s_tuser,   // [1:0] req_type
  // Result stream.
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata    // [3:0] led_mask, [7:4] zero
);

  // Input fields.
  logic [1:0] in_channel;
  logic [7:0] in_level;
  dmxlb_pkg::req_type_t in_req;

  assign in_channel = s_tdata[1:0];
  assign in_level   = s_tdata[9:2];
  assign in_req     = dmxlb_pkg::req_type_t'(s_tuser);

  // Control state.
  dmxlb_pkg::state_t state, state_next;
  logic [1:0]  cur_ch;
  logic [dmxlb_pkg::STEP_W-1:0] step;
  logic [dmxlb_pkg::BLINK_W-1:0] blink_count;
  logic [dmxlb_pkg::TO_W-1:0] timeout_count;
  logic [7:0]  timeout_seconds;
  logic [dmxlb_pkg::CHANNELS-1:0] lvl_valid;

  // Level memory with a registered read port.
  logic [7:0] level_mem [dmxlb_pkg::CHANNELS];
  logic [7:0] rd_data;
  logic       rd_valid;

  // Divider datapath.
  logic [7:0] period;
  logic [7:0] rem;
  logic [dmxlb_pkg::BLINK_W-1:0] dividend;
  logic [8:0] rem_shift;
  logic       rem_ge;
  logic [3:0] mask;

  // Handshake and decode.
  logic in_fire;
  logic out_load;
  logic last_ch;
  logic last_step;
  logic lvl_zero;
  logic wr_en;
  logic [dmxlb_pkg::ADDR_W-1:0] wr_addr;
  logic [dmxlb_pkg::ADDR_W-1:0] rd_addr;
  logic [dmxlb_pkg::TO_W-1:0] limit;
  logic [dmxlb_pkg::TO_W-1:0] to_inc;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign out_load  = (state == dmxlb_pkg::ST_DONE) && (!m_tvalid || m_tready);
  assign last_ch   = (32'(cur_ch) == 32'(dmxlb_pkg::MASK_CH - 1));
  assign last_step = (step == dmxlb_pkg::STEP_W'(dmxlb_pkg::BLINK_W - 1));
  assign lvl_zero  = !rd_valid || (rd_data == 8'd0);

  // A level write to a channel beyond the store is dropped.
  assign wr_en   = in_fire && (in_req == dmxlb_pkg::REQ_WRITE_LEVEL) &&
                   (32'(in_channel) < 32'(dmxlb_pkg::CHANNELS));
  assign wr_addr = dmxlb_pkg::ADDR_W'(in_channel);
  assign rd_addr = dmxlb_pkg::ADDR_W'(cur_ch);

  assign limit  = dmxlb_pkg::TO_W'(32'(timeout_seconds) * dmxlb_pkg::TICKS_PER_SECOND);
  assign to_inc = timeout_count + dmxlb_pkg::TO_W'(1);

  // One restoring division step: bring in the next dividend bit.
  assign rem_shift = {rem, dividend[dmxlb_pkg::BLINK_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, period});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level_mem[wr_addr] <= in_level;
    end
    rd_data  <= level_mem[rd_addr];
    rd_valid <= lvl_valid[rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dmxlb_pkg::ST_IDLE: begin
        if (in_fire && (in_req == dmxlb_pkg::REQ_BLINK_TICK)) begin
          state_next = dmxlb_pkg::ST_READ;
        end
      end
      dmxlb_pkg::ST_READ: state_next = dmxlb_pkg::ST_LOAD;
      dmxlb_pkg::ST_LOAD: begin
        if (!lvl_zero) begin
          state_next = dmxlb_pkg::ST_DIV;
        end else if (last_ch) begin
          state_next = dmxlb_pkg::ST_DONE;
        end else begin
          state_next = dmxlb_pkg::ST_READ;
        end
      end
      dmxlb_pkg::ST_DIV: begin
        if (last_step) begin
          state_next = last_ch ? dmxlb_pkg::ST_DONE : dmxlb_pkg::ST_READ;
        end
      end
      dmxlb_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = dmxlb_pkg::ST_IDLE;
        end
      end
      default: state_next = dmxlb_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    case (state)
      dmxlb_pkg::ST_IDLE: s_tready = 1'b1;
      default:            s_tready = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= dmxlb_pkg::ST_IDLE;
      cur_ch          <= 2'd0;
      step            <= '0;
      blink_count     <= '0;
      timeout_count   <= '0;
      timeout_seconds <= 8'd0;
      lvl_valid       <= '0;
      m_tvalid        <= 1'b0;
      mask            <= 4'd0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        timeout_seconds <= cfg_data;
      end

      if (wr_en) begin
        lvl_valid[wr_addr] <= 1'b1;
      end

      if (in_fire) begin
        case (in_req)
          dmxlb_pkg::REQ_ACTIVITY: timeout_count <= '0;
          dmxlb_pkg::REQ_BLINK_TICK: begin
            cur_ch <= 2'd0;
            mask   <= 4'd0;
          end
          dmxlb_pkg::REQ_TIMEOUT_TICK: begin
            // A zero limit holds the counter.
            if (limit != '0) begin
              if (to_inc >= limit) begin
                lvl_valid     <= '0;
                timeout_count <= '0;
              end else begin
                timeout_count <= to_inc;
              end
            end
          end
          default: ;
        endcase
      end

      case (state)
        dmxlb_pkg::ST_LOAD: begin
          step <= '0;
          if (lvl_zero && !last_ch) begin
            cur_ch <= cur_ch + 2'd1;
          end
        end
        dmxlb_pkg::ST_DIV: begin
          step <= step + dmxlb_pkg::STEP_W'(1);
          if (last_step) begin
            // The last quotient bit is the parity of count / period.
            mask[cur_ch] <= rem_ge;
            if (!last_ch) begin
              cur_ch <= cur_ch + 2'd1;
            end
          end
        end
        default: ;
      endcase

      if (out_load) begin
        m_tvalid    <= 1'b1;
        blink_count <= blink_count + dmxlb_pkg::BLINK_W'(1);
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Divider and result payload registers.
  always_ff @(posedge clk) begin
    case (state)
      dmxlb_pkg::ST_LOAD: begin
        // period = (level xor 255) / 2 + 10, at most 137.
        period   <= {1'b0, ~rd_data[7:1]} + 8'(dmxlb_pkg::PERIOD_OFFSET);
        rem      <= 8'd0;
        dividend <= blink_count;
      end
      dmxlb_pkg::ST_DIV: begin
        rem      <= rem_ge ? 8'(rem_shift - {1'b0, period}) : rem_shift[7:0];
        dividend <= {dividend[dmxlb_pkg::BLINK_W-2:0], 1'b0};
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {4'd0, mask};
    end
  end

  // Checks.
  a_mask_upper_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((32'(m_tdata) >> dmxlb_pkg::MASK_CH) == 32'd0))
    else $error("led_mask has bits set above the shown channels");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && (state == dmxlb_pkg::ST_IDLE))
    else $error("finished blink tick did not present its mask");

  a_timeout_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(timeout_count) < 32'(dmxlb_pkg::TO_MAX))
    else $error("timeout counter beyond its largest limit");

  a_div_channel_range: assert property (@(posedge clk) disable iff (rst)
    (state == dmxlb_pkg::ST_DIV) |-> (32'(cur_ch) < 32'(dmxlb_pkg::MASK_CH)))
    else $error("divider working on a channel outside the mask");

endmodule

`default_nettype wire

FILE: tb/tb_dmx_level_blink_with_timeout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dmx_level_blink_with_timeout
// Self-checking bench for the DMX level store with LED blink and timeout.
// Items are queued by a stimulus process, offered in bursts by a clocked
// driver, and mirrored at every input transfer into a local model of the
// level store, blink count and timeout counter. A clocked monitor compares
// each led_mask transfer with the oldest predicted mask.
// ----------------------------------------------------------------------------
module tb_dmx_level_blink_with_timeout;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 5;
  // A blink tick finishes well within this pause, so it covers any work still
  // going on when the last mask has arrived.
  localparam int SETTLE_CYCLES = 200;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLDOFF_CYCLES = 1500;
  // Cycles without any transfer before the run is declared hung. The worst
  // quiet stretch of a correct run is the hold-off plus one blink tick.
  localparam int WATCHDOG_LIMIT = 20000;

  // One input item as the block sees it.
  typedef struct packed {
    dmxlb_pkg::req_type_t req;
    logic [1:0]           channel;
    logic [7:0]           level;
  } dmx_item_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [1:0] channel, [9:2] level, [15:10] zero
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [3:0] led_mask, [7:4] zero

  always #(CLK_PERIOD / 2) clk = ~clk;

  dmx_level_blink_with_timeout u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Local copy of the block state, advanced at every accepted input transfer.
  // --------------------------------------------------------------------------
  logic [7:0]                 level_store [dmxlb_pkg::CHANNELS];
  logic [31:0]                blink_ticks;
  logic [dmxlb_pkg::TO_W-1:0] quiet_ticks;
  logic [7:0]                 timeout_secs;

  dmx_item_t  pending_items[$];   // items not yet offered to the block
  logic [3:0] expected_masks[$];  // predicted masks not yet transferred
  int         errors = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic void reset_model();
    for (int n = 0; n < dmxlb_pkg::CHANNELS; n++) level_store[n] = 8'd0;
    blink_ticks = '0;
    quiet_ticks = '0;
    timeout_secs = 8'd0;
  endfunction

  // A lit channel toggles every (level xor 0xFF)/2 + 10 blink ticks; it is on
  // in the odd half-periods. A zero level keeps the LED dark.
  function automatic logic [3:0] blink_mask();
    logic [3:0]  mask;
    logic [31:0] period;
    mask = '0;
    for (int n = 0; n < dmxlb_pkg::MASK_CH; n++) begin
      if (level_store[n] != 8'd0) begin
        period = {24'd0, level_store[n] ^ 8'hFF};
        period = period / 2 + dmxlb_pkg::PERIOD_OFFSET;
        if (((blink_ticks / period) & 32'd1) != 32'd0) mask[n] = 1'b1;
      end
    end
    return mask;
  endfunction

  function automatic void apply_dmx_item(input dmx_item_t it);
    int unsigned limit;
    case (it.req)
      dmxlb_pkg::REQ_WRITE_LEVEL: begin
        if (it.channel < dmxlb_pkg::CHANNELS) level_store[it.channel] = it.level;
      end
      dmxlb_pkg::REQ_ACTIVITY: begin
        quiet_ticks = '0;
      end
      dmxlb_pkg::REQ_BLINK_TICK: begin
        expected_masks.push_back(blink_mask());
        blink_ticks = blink_ticks + 32'd1;
      end
      default: begin
        // A setting of zero holds the counter. Once the count reaches the
        // limit, even one that was just lowered below it, the levels clear.
        limit = timeout_secs * dmxlb_pkg::TICKS_PER_SECOND;
        if (limit != 0) begin
          quiet_ticks = quiet_ticks + 1'b1;
          if (quiet_ticks >= limit) begin
            for (int n = 0; n < dmxlb_pkg::CHANNELS; n++) level_store[n] = 8'd0;
            quiet_ticks = '0;
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic dmx_item_t make_item(input dmxlb_pkg::req_type_t req,
                                          input logic [1:0] ch,
                                          input logic [7:0] lvl);
    dmx_item_t it;
    it.req = req;
    it.channel = ch;
    it.level = lvl;
    return it;
  endfunction

  function automatic dmx_item_t random_item();
    int unsigned          pick;
    logic [7:0]           lvl;
    dmxlb_pkg::req_type_t req;
    pick = $urandom_range(99);
    case ($urandom_range(7))
      0:       lvl = 8'h00;
      1:       lvl = 8'hFF;
      2:       lvl = 8'h01;
      default: lvl = 8'($urandom);
    endcase
    if (pick < 35) req = dmxlb_pkg::REQ_WRITE_LEVEL;
    else if (pick < 45) req = dmxlb_pkg::REQ_ACTIVITY;
    else if (pick < 75) req = dmxlb_pkg::REQ_BLINK_TICK;
    else req = dmxlb_pkg::REQ_TIMEOUT_TICK;
    // Non-write items still carry random channel and level bits as noise.
    return make_item(req, 2'($urandom_range(3)), lvl);
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_items.push_back(random_item());
  endtask

  task automatic queue_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      pending_items.push_back(make_item(dmxlb_pkg::REQ_TIMEOUT_TICK,
                                        2'($urandom_range(3)), 8'($urandom)));
    end
  endtask

  // Light every channel, restart the timeout and run the given number of
  // timeout ticks, then blink once to show whether the levels survived.
  task automatic queue_timeout_run(input int ticks);
    for (int n = 0; n < dmxlb_pkg::CHANNELS; n++) begin
      pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'(n),
                                        8'($urandom_range(1, 255))));
    end
    pending_items.push_back(make_item(dmxlb_pkg::REQ_ACTIVITY, 2'd0, 8'd0));
    queue_ticks(ticks);
    pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd0, 8'd0));
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued items in bursts with random gaps. The model is
  // advanced at the edge where a transfer completes.
  // --------------------------------------------------------------------------
  dmx_item_t offered_item;
  logic      drv_busy = 1'b0;   // an item is on the bus, read by the stimulus
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      drv_busy = 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_dmx_item(offered_item);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          offered_item = pending_items.pop_front();
          s_tdata <= {6'd0, offered_item.level, offered_item.channel};
          s_tuser <= offered_item.req;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Mostly short bursts, now and then a long stretch with no gaps.
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_tvalid <= offer;
      drv_busy = offer;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every mask transfer and drives m_tready from a rotating
  // random pattern. A request from the stimulus starts a long hold-off that
  // lets the output register fill and the block stall its input.
  // --------------------------------------------------------------------------
  int         holdoff_req = 0;
  int         holdoff_seen = 0;
  int         hold_left = 0;
  logic [7:0] ready_pat = 8'hFF;
  int         pat_pos = 0;

  always @(posedge clk) begin
    logic [3:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_masks.size() == 0) begin
          report_mismatch($sformatf("led_mask transfer %h with nothing expected", m_tdata));
        end else begin
          want = expected_masks.pop_front();
          if (m_tdata[3:0] !== want)
            report_mismatch($sformatf("led_mask %h, expected %h", m_tdata[3:0], want));
          if (m_tdata[7:4] !== 4'd0)
            report_mismatch($sformatf("tdata pad bits %h not zero", m_tdata[7:4]));
        end
      end
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (pat_pos == 0) ready_pat = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
        m_tready <= ready_pat[pat_pos];
        pat_pos = (pat_pos + 1) % 8;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run that goes quiet for too long has hung.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Idle detection and register writes.
  // --------------------------------------------------------------------------
  // Waits until every item has been transferred and every mask has come
  // back, then lets the block finish anything still in progress.
  task automatic wait_quiet();
    while (pending_items.size() != 0 || drv_busy || expected_masks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The setting changes only the limit; the counter is left as it is.
  task automatic set_timeout(input logic [7:0] secs);
    wait_quiet();
    @(posedge clk);
    cfg_data <= secs;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    timeout_secs = secs;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, timeout disabled after reset. All LEDs dark at first,
    // and a timeout tick must leave the held counter alone.
    pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd0, 8'd0));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_TIMEOUT_TICK, 2'd3, 8'hFF));
    // Level extremes: shortest period, longest period, midscale, dark.
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd0, 8'hFF));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd1, 8'h01));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd2, 8'h80));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd3, 8'h00));
    repeat (3) pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd1, 8'h55));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd3, 8'h55));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd2, 8'hAA));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd2, 8'hAA));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_ACTIVITY, 2'd3, 8'hFF));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd1, 8'hFE));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd3, 8'h7F));
    repeat (2) pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd0, 8'd0));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_TIMEOUT_TICK, 2'd0, 8'd0));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_WRITE_LEVEL, 2'd0, 8'h00));
    pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd3, 8'hFF));

    // One second: levels survive one tick short of the limit and clear on
    // the tick that reaches it.
    set_timeout(8'd1);
    queue_timeout_run(dmxlb_pkg::TICKS_PER_SECOND - 1);
    queue_ticks(1);
    pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd0, 8'd0));
    queue_random(150);
    holdoff_req++;
    queue_random(100);
    queue_timeout_run(dmxlb_pkg::TICKS_PER_SECOND - 3 + $urandom_range(0, 6));

    // Longest setting: the counter runs well past one second without a clear.
    set_timeout(8'd255);
    queue_random(150);
    queue_timeout_run(12000);

    // Lowering the limit below the elapsed count clears on the next tick.
    set_timeout(8'd1);
    pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd0, 8'd0));
    queue_ticks(1);
    pending_items.push_back(make_item(dmxlb_pkg::REQ_BLINK_TICK, 2'd0, 8'd0));

    // Disabled again: ticks are held, restarts still clear the counter.
    set_timeout(8'd0);
    queue_random(150);
    queue_timeout_run(500);

    // Two seconds, with a second hold-off while items keep coming.
    set_timeout(8'd2);
    queue_random(150);
    queue_timeout_run(2 * dmxlb_pkg::TICKS_PER_SECOND - 2 + $urandom_range(0, 4));
    holdoff_req++;
    queue_random(100);

    wait_quiet();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
